// File: hdl/met_pkg.sv
// ----------------------------------------------------------------------------
// met_pkg
// Shared widths, reset values, register indexes, control structs and the
// Q6.26 saturation helper of the escape-time pixel engine.
// ----------------------------------------------------------------------------
`default_nettype none

package met_pkg;

    localparam int DIM_BITS       = 12;
    localparam int ITER_BITS      = 16;
    localparam int FRAC_BITS      = 26;
    localparam int Q_BITS         = 32;
    localparam int STEP_BITS      = 27;
    localparam int OFS_BITS       = 30;
    localparam int CFG_DATA_BITS  = 30;
    localparam int CFG_INDEX_BITS = 3;
    localparam int PROD_BITS      = 2 * Q_BITS;
    localparam int MAP_D_BITS     = DIM_BITS + 2;
    localparam int MAP_P_BITS     = MAP_D_BITS + STEP_BITS + 1;
    localparam int SUM_BITS       = 48;

    localparam logic [DIM_BITS-1:0]         DEFAULT_WIDTH      = DIM_BITS'(1280);
    localparam logic [DIM_BITS-1:0]         DEFAULT_HEIGHT     = DIM_BITS'(900);
    localparam logic [ITER_BITS-1:0]        RESET_MAX_ITER     = ITER_BITS'(1000);
    localparam logic [STEP_BITS-1:0]        RESET_PIXEL_STEP   = STEP_BITS'(335544);
    localparam logic signed [OFS_BITS-1:0]  RESET_OFFSET_REAL  = -30'sd33554432;
    localparam logic signed [OFS_BITS-1:0]  RESET_OFFSET_IMAG  = '0;

    // Escape threshold: |z|^2 > 4 in Q12.52.
    localparam logic [PROD_BITS-1:0] ESCAPE_LIMIT = PROD_BITS'(1) << (2 * FRAC_BITS + 2);

    localparam logic signed [SUM_BITS-1:0] SAT_HI =
        {{(SUM_BITS-Q_BITS+1){1'b0}}, {(Q_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SAT_LO =
        {{(SUM_BITS-Q_BITS+1){1'b1}}, {(Q_BITS-1){1'b0}}};

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_MAX_ITER     = 3'd2,
        REG_PIXEL_STEP   = 3'd3,
        REG_OFFSET_REAL  = 3'd4,
        REG_OFFSET_IMAG  = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [DIM_BITS-1:0]        image_width;
        logic [DIM_BITS-1:0]        image_height;
        logic [ITER_BITS-1:0]       max_iterations;
        logic [STEP_BITS-1:0]       pixel_step;
        logic signed [OFS_BITS-1:0] offset_real;
        logic signed [OFS_BITS-1:0] offset_imag;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic map_real;
        logic map_imag;
        logic multiply;
        logic step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic escape;
    } dp_status_t;

    // Clamp a wide signed sum to the signed Q6.26 range.
    function automatic logic signed [Q_BITS-1:0] sat_q(input logic signed [SUM_BITS-1:0] v);
        logic signed [SUM_BITS-1:0] r;
        begin
            if (v > SAT_HI) begin
                r = SAT_HI;
            end else if (v < SAT_LO) begin
                r = SAT_LO;
            end else begin
                r = v;
            end
            return r[Q_BITS-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// File: hdl/mandelbrot_escape_time_pixel.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// Escape-time evaluation of one pixel: maps the pixel to a point c of the
// complex plane in signed Q6.26 and counts iterations of z = z*z + c.
// ----------------------------------------------------------------------------
// Each iteration takes a multiply step (the three registered 32x32 products)
// followed by an escape-test and z-update step. One pixel is processed at a
// time: a new input word is accepted only once the previous result has been
// moved to the output register. Synchronous active-low reset empties the
// engine and loads the documented register defaults; no clearing pass is
// needed.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_time_pixel
    import met_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // Configuration write port.
    input  wire logic                      cfg_wr_en,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_wr_data,
    // Pixel input channel.
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [DIM_BITS-1:0]       s_pixel_x,
    input  wire logic [DIM_BITS-1:0]       s_pixel_y,
    // Result channel.
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [ITER_BITS-1:0]           m_iteration_count,
    output logic                           m_inside_set
);

    // The controller sequences each pixel through the mapping cycles (real
    // then imaginary axis, sharing one multiplier), then alternates between
    // a multiply cycle and a test/update cycle until the point escapes or the
    // iteration limit is met. The final count is copied into an output
    // register, so a new input word is taken while the result still waits to
    // be collected; a second result only stalls if that register is full.

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    met_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    met_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    met_dp u_dp (
        .aclk              (aclk),
        .cfg               (cfg),
        .cmd               (cmd),
        .status            (status),
        .s_pixel_x         (s_pixel_x),
        .s_pixel_y         (s_pixel_y),
        .m_iteration_count (m_iteration_count),
        .m_inside_set      (m_inside_set)
    );

endmodule

`default_nettype wire

// File: hdl/met_cfg.sv
// ----------------------------------------------------------------------------
// met_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module met_cfg
    import met_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_wr_data,
    output cfg_t                           cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  cfg_next.image_width    = cfg_wr_data[DIM_BITS-1:0];
                REG_IMAGE_HEIGHT: cfg_next.image_height   = cfg_wr_data[DIM_BITS-1:0];
                REG_MAX_ITER:     cfg_next.max_iterations = cfg_wr_data[ITER_BITS-1:0];
                REG_PIXEL_STEP:   cfg_next.pixel_step     = cfg_wr_data[STEP_BITS-1:0];
                REG_OFFSET_REAL:  cfg_next.offset_real    = $signed(cfg_wr_data[OFS_BITS-1:0]);
                REG_OFFSET_IMAG:  cfg_next.offset_imag    = $signed(cfg_wr_data[OFS_BITS-1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width    <= DEFAULT_WIDTH;
            cfg_reg.image_height   <= DEFAULT_HEIGHT;
            cfg_reg.max_iterations <= RESET_MAX_ITER;
            cfg_reg.pixel_step     <= RESET_PIXEL_STEP;
            cfg_reg.offset_real    <= RESET_OFFSET_REAL;
            cfg_reg.offset_imag    <= RESET_OFFSET_IMAG;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: hdl/met_ctrl.sv
// ----------------------------------------------------------------------------
// met_ctrl
// Sequencer for one pixel: mapping, multiply/test iterations, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module met_ctrl
    import met_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    input  dp_status_t status,
    output dp_cmd_t   cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP_RE,
        ST_MAP_IM,
        ST_MULT,
        ST_TEST,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        cmd.capture  = (state_reg == ST_IDLE) && s_valid;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_MAP_RE;
                end
            end
            ST_MAP_RE: begin
                cmd.map_real = 1'b1;
                state_next   = ST_MAP_IM;
            end
            ST_MAP_IM: begin
                cmd.map_imag = 1'b1;
                state_next   = ST_MULT;
            end
            ST_MULT: begin
                cmd.multiply = 1'b1;
                state_next   = ST_TEST;
            end
            ST_TEST: begin
                if (status.escape) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.step   = 1'b1;
                    state_next = ST_MULT;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// File: hdl/met_dp.sv
// ----------------------------------------------------------------------------
// met_dp
// Datapath: pixel-to-plane mapping, squaring products, escape test, z update
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module met_dp
    import met_pkg::*;
(
    input  wire logic                 aclk,
    input  cfg_t                      cfg,
    input  dp_cmd_t                   cmd,
    output dp_status_t                status,
    input  wire logic [DIM_BITS-1:0]  s_pixel_x,
    input  wire logic [DIM_BITS-1:0]  s_pixel_y,
    output logic [ITER_BITS-1:0]      m_iteration_count,
    output logic                      m_inside_set
);

    logic [DIM_BITS-1:0]         px_reg, py_reg;
    logic signed [Q_BITS-1:0]    cr_reg, ci_reg, zr_reg, zi_reg;
    logic signed [Q_BITS-1:0]    zr_next, zi_next;
    logic signed [PROD_BITS-1:0] rr_reg, ii_reg, ri_reg;
    logic [ITER_BITS-1:0]        count_reg, count_next;
    logic [ITER_BITS-1:0]        out_count_reg;
    logic                        out_inside_reg;

    // Mapping: one shared multiplier serves both axes on successive cycles.
    logic [DIM_BITS-1:0]          map_pixel, map_size, width_eff, height_eff;
    logic signed [OFS_BITS-1:0]   map_offset;
    logic signed [MAP_D_BITS-1:0] map_d;
    logic signed [MAP_P_BITS-1:0] map_prod;
    logic signed [Q_BITS-1:0]     map_q;

    assign width_eff  = (cfg.image_width  == '0) ? DEFAULT_WIDTH  : cfg.image_width;
    assign height_eff = (cfg.image_height == '0) ? DEFAULT_HEIGHT : cfg.image_height;
    assign map_pixel  = cmd.map_imag ? py_reg : px_reg;
    assign map_size   = cmd.map_imag ? height_eff : width_eff;
    assign map_offset = cmd.map_imag ? cfg.offset_imag : cfg.offset_real;

    assign map_d    = $signed({1'b0, map_pixel, 1'b0}) - $signed({2'b00, map_size});
    assign map_prod = MAP_P_BITS'(map_d) * $signed({1'b0, cfg.pixel_step});
    assign map_q    = sat_q(SUM_BITS'(map_prod >>> 1) + SUM_BITS'(map_offset));

    // Escape test and next z from the registered products.
    logic [PROD_BITS-1:0]        mag;
    logic signed [PROD_BITS-1:0] diff;
    logic signed [PROD_BITS-1:0] diff_sh, ri_sh;

    assign mag     = $unsigned(rr_reg) + $unsigned(ii_reg);
    assign diff    = rr_reg - ii_reg;
    assign diff_sh = diff >>> FRAC_BITS;
    assign ri_sh   = ri_reg >>> (FRAC_BITS - 1);
    assign zr_next = sat_q(SUM_BITS'(diff_sh) + SUM_BITS'(cr_reg));
    assign zi_next = sat_q(SUM_BITS'(ri_sh) + SUM_BITS'(ci_reg));
    assign count_next = count_reg + ITER_BITS'(1);

    assign status.escape = (mag > ESCAPE_LIMIT) || (count_reg >= cfg.max_iterations);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            px_reg <= s_pixel_x;
            py_reg <= s_pixel_y;
        end
        if (cmd.map_real) begin
            cr_reg <= map_q;
        end
        if (cmd.map_imag) begin
            ci_reg    <= map_q;
            zr_reg    <= cr_reg;
            zi_reg    <= map_q;
            count_reg <= '0;
        end
        if (cmd.multiply) begin
            rr_reg <= zr_reg * zr_reg;
            ii_reg <= zi_reg * zi_reg;
            ri_reg <= zr_reg * zi_reg;
        end
        if (cmd.step) begin
            zr_reg    <= zr_next;
            zi_reg    <= zi_next;
            count_reg <= count_next;
        end
        if (cmd.load_out) begin
            out_count_reg  <= count_reg;
            out_inside_reg <= (count_reg == cfg.max_iterations);
        end
    end

    assign m_iteration_count = out_count_reg;
    assign m_inside_set      = out_inside_reg;

endmodule

`default_nettype wire
